FILE: rtl/core/fra_pkg.sv
package fra_pkg;

    // operation codes carried on the op field
    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    // fixed result field widths
    localparam int NUM_W = 18;
    localparam int DEN_W = 16;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_MUL0 = 9'b000000010,
        S_MUL1 = 9'b000000100,
        S_MUL2 = 9'b000001000,
        S_COMB = 9'b000010000,
        S_GCD  = 9'b000100000,
        S_DIVN = 9'b001000000,
        S_DIVD = 9'b010000000,
        S_OUT  = 9'b100000000
    } state_t;

endpackage

FILE: rtl/core/fraction_arith_reduce_unit.sv
// Fraction arithmetic with reduction to lowest terms.
// Input channel (in_valid/in_ready): op and the fractions num_a/den_a and
// num_b/den_b. op selects add, subtract, multiply or divide (a/b over c/d
// divided gives num_a*den_b over den_a*num_b).
// Output channel (out_valid/out_ready): res_num (signed, carries the sign)
// and res_den (positive). A whole result has res_den 1, a zero result is 0/1,
// and a zero unreduced denominator gives the error code 0/0.
// One item is worked at a time; in_ready is high only while the unit is idle.
// With W = OPERAND_BITS and M = 2*W+1, one item takes three products on the
// single W x W multiplier, a combine step, a binary gcd on the shared
// subtractor, then two M-bit restoring divides (numerator, then denominator)
// on the same subtractor and an output step before out_valid. Zero and error
// results skip the gcd and the divides. in_ready comes back with out_valid.
// A finished result sits in the output register; the next input beat is
// accepted while it waits, but the following result holds in the last step
// until the receiver takes the earlier beat.
// Reset (rst_n low, asynchronous) returns the sequencer to idle and drops
// out_valid; nothing else needs clearing.
module fraction_arith_reduce_unit #(
    parameter int OPERAND_BITS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        op,
    input  logic [OPERAND_BITS-1:0]           num_a,
    input  logic [OPERAND_BITS-1:0]           den_a,
    input  logic [OPERAND_BITS-1:0]           num_b,
    input  logic [OPERAND_BITS-1:0]           den_b,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [fra_pkg::NUM_W-1:0]  res_num,
    output logic [fra_pkg::DEN_W-1:0]         res_den
);

    localparam int W   = OPERAND_BITS;
    localparam int PW  = 2 * W;
    localparam int MW  = 2 * W + 1;
    localparam int CW  = $clog2(MW + 1);
    localparam int XW  = (MW + 1 > fra_pkg::NUM_W) ? MW + 1 : fra_pkg::NUM_W;
    localparam int DXW = (MW > fra_pkg::DEN_W) ? MW : fra_pkg::DEN_W;

    fra_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;
    logic [CW-1:0]   cnt_reg, cnt_next;

    fra_pkg::op_t    op_reg, op_next;
    logic [W-1:0]    a_reg, a_next, b_reg, b_next, c_reg, c_next, d_reg, d_next;
    logic [PW-1:0]   p_reg, p_next, q_reg, q_next;
    logic [MW-1:0]   mag_reg, mag_next, den_reg, den_next;
    logic            neg_reg, neg_next;
    logic [MW-1:0]   u_reg, u_next, v_reg, v_next, g_reg, g_next;
    logic [fra_pkg::NUM_W-1:0] res_num_reg, res_num_next;
    logic [fra_pkg::DEN_W-1:0] res_den_reg, res_den_next;

    // shared multiplier and subtractor
    logic [W-1:0]    mul_x, mul_y;
    logic [PW-1:0]   mul_p;
    logic [MW:0]     sub_a, sub_b, diff, diff_neg;
    logic [MW:0]     trial_a;
    logic [MW-1:0]   sum_pq;
    logic            quo_bit;
    logic [MW-1:0]   div_u, div_v;
    logic [XW-1:0]   num_ext;
    logic [DXW-1:0]  den_ext;

    assign mul_p    = PW'(mul_x) * PW'(mul_y);
    assign diff     = sub_a - sub_b;
    assign diff_neg = (MW + 1)'(0) - diff;
    assign sum_pq   = MW'(p_reg) + MW'(q_reg);
    assign trial_a  = {v_reg, u_reg[MW-1]};

    // one restoring divide step on the shared subtractor
    assign quo_bit  = ~diff[MW];
    assign div_u    = {u_reg[MW-2:0], quo_bit};
    assign div_v    = quo_bit ? diff[MW-1:0] : trial_a[MW-1:0];

    assign num_ext  = neg_reg ? (XW'(0) - XW'(mag_reg)) : XW'(mag_reg);
    assign den_ext  = DXW'(den_reg);

    always_comb
    begin
        mul_x = a_reg;
        mul_y = d_reg;
        sub_a = {1'b0, u_reg};
        sub_b = {1'b0, v_reg};
        unique case (state_reg) inside
            fra_pkg::S_MUL0:
            begin
                mul_x = a_reg;
                mul_y = (op_reg == fra_pkg::OP_MUL) ? c_reg : d_reg;
            end
            fra_pkg::S_MUL1:
            begin
                mul_x = b_reg;
                mul_y = c_reg;
            end
            fra_pkg::S_MUL2:
            begin
                mul_x = b_reg;
                mul_y = (op_reg == fra_pkg::OP_DIV) ? c_reg : d_reg;
            end
            fra_pkg::S_COMB:
            begin
                sub_a = (MW + 1)'(p_reg);
                sub_b = (MW + 1)'(q_reg);
            end
            fra_pkg::S_DIVN, fra_pkg::S_DIVD:
            begin
                sub_a = trial_a;
                sub_b = {1'b0, g_reg};
            end
            default:
            begin
                sub_a = {1'b0, u_reg};
                sub_b = {1'b0, v_reg};
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cnt_next       = cnt_reg;
        op_next        = op_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        d_next         = d_reg;
        p_next         = p_reg;
        q_next         = q_reg;
        mag_next       = mag_reg;
        den_next       = den_reg;
        neg_next       = neg_reg;
        u_next         = u_reg;
        v_next         = v_reg;
        g_next         = g_reg;
        res_num_next   = res_num_reg;
        res_den_next   = res_den_reg;

        unique case (state_reg)
            fra_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = fra_pkg::op_t'(op);
                    a_next     = num_a;
                    b_next     = den_a;
                    c_next     = num_b;
                    d_next     = den_b;
                    state_next = fra_pkg::S_MUL0;
                end
            end
            fra_pkg::S_MUL0:
            begin
                p_next     = mul_p;
                state_next = fra_pkg::S_MUL1;
            end
            fra_pkg::S_MUL1:
            begin
                q_next     = mul_p;
                state_next = fra_pkg::S_MUL2;
            end
            fra_pkg::S_MUL2:
            begin
                den_next   = MW'(mul_p);
                state_next = fra_pkg::S_COMB;
            end
            fra_pkg::S_COMB:
            begin
                neg_next = 1'b0;
                case (op_reg)
                    fra_pkg::OP_ADD: mag_next = sum_pq;
                    fra_pkg::OP_SUB:
                    begin
                        neg_next = diff[MW];
                        mag_next = diff[MW] ? diff_neg[MW-1:0] : diff[MW-1:0];
                    end
                    default:         mag_next = MW'(p_reg);
                endcase
                u_next     = mag_next;
                v_next     = den_reg;
                state_next = fra_pkg::S_GCD;
                if (den_reg == '0)
                begin
                    mag_next   = '0;
                    neg_next   = 1'b0;
                    state_next = fra_pkg::S_OUT;
                end
                else if (mag_next == '0)
                begin
                    den_next   = MW'(1);
                    neg_next   = 1'b0;
                    state_next = fra_pkg::S_OUT;
                end
            end
            fra_pkg::S_GCD:
            begin
                if (u_reg == '0 || v_reg == '0)
                begin
                    g_next     = u_reg | v_reg;
                    u_next     = mag_reg;
                    v_next     = '0;
                    cnt_next   = '0;
                    state_next = fra_pkg::S_DIVN;
                end
                else if (!u_reg[0] && !v_reg[0])
                begin
                    // common factor of two comes off the operands themselves
                    u_next   = u_reg >> 1;
                    v_next   = v_reg >> 1;
                    mag_next = mag_reg >> 1;
                    den_next = den_reg >> 1;
                end
                else if (!u_reg[0])
                begin
                    u_next = u_reg >> 1;
                end
                else if (!v_reg[0])
                begin
                    v_next = v_reg >> 1;
                end
                else if (!diff[MW])
                begin
                    u_next = {1'b0, diff[MW-1:1]};
                end
                else
                begin
                    v_next = {1'b0, diff_neg[MW-1:1]};
                end
            end
            fra_pkg::S_DIVN:
            begin
                u_next   = div_u;
                v_next   = div_v;
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(MW - 1))
                begin
                    mag_next   = div_u;
                    u_next     = den_reg;
                    v_next     = '0;
                    cnt_next   = '0;
                    state_next = fra_pkg::S_DIVD;
                end
            end
            fra_pkg::S_DIVD:
            begin
                u_next   = div_u;
                v_next   = div_v;
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(MW - 1))
                begin
                    den_next   = div_u;
                    cnt_next   = '0;
                    state_next = fra_pkg::S_OUT;
                end
            end
            fra_pkg::S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    res_num_next   = num_ext[fra_pkg::NUM_W-1:0];
                    res_den_next   = den_ext[fra_pkg::DEN_W-1:0];
                    out_valid_next = 1'b1;
                    state_next     = fra_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = fra_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fra_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        c_reg       <= c_next;
        d_reg       <= d_next;
        p_reg       <= p_next;
        q_reg       <= q_next;
        mag_reg     <= mag_next;
        den_reg     <= den_next;
        neg_reg     <= neg_next;
        u_reg       <= u_next;
        v_reg       <= v_next;
        g_reg       <= g_next;
        res_num_reg <= res_num_next;
        res_den_reg <= res_den_next;
    end

    assign in_ready  = (state_reg == fra_pkg::S_IDLE);
    assign out_valid = out_valid_reg;
    assign res_num   = res_num_reg;
    assign res_den   = res_den_reg;

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("unit took a beat while still working");

    a_gcd_operands: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == fra_pkg::S_GCD |-> (u_reg != '0 || v_reg != '0))
        else $error("gcd operands both zero");

    a_error_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && res_den == '0 |-> res_num == '0)
        else $error("zero denominator with nonzero numerator");
`endif

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int OPW = 8;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 100;

    typedef struct {
        logic signed [fra_pkg::NUM_W-1:0] num;
        logic [fra_pkg::DEN_W-1:0]        den;
        string                            what;
    } frac_t;

    class frac_scoreboard;
        frac_t expected_fracs[$];
        int    mismatches = 0;

        task report(string msg);
            $display("mismatch: %s", msg);
            mismatches++;
        endtask

        // multiply out per op, then cut down by the gcd; sign rides on the numerator
        static function frac_t reduce_fraction(fra_pkg::op_t o,
                                               logic [OPW-1:0] a, logic [OPW-1:0] b,
                                               logic [OPW-1:0] c, logic [OPW-1:0] d);
            logic [63:0] mag, den, p, q, x, y, r, rn, rd;
            bit          neg;
            frac_t       f;
            neg = 1'b0;
            case (o)
                fra_pkg::OP_ADD:
                begin
                    mag = a * d + b * c;
                    den = b * d;
                end
                fra_pkg::OP_SUB:
                begin
                    p = a * d;
                    q = b * c;
                    den = b * d;
                    if (p >= q) mag = p - q;
                    else
                    begin
                        mag = q - p;
                        neg = 1'b1;
                    end
                end
                fra_pkg::OP_MUL:
                begin
                    mag = a * c;
                    den = b * d;
                end
                default:
                begin
                    mag = a * d;
                    den = b * c;
                end
            endcase
            f.what = $sformatf("%s %0d/%0d, %0d/%0d", o.name(), a, b, c, d);
            if (den == 0)
            begin
                f.num = '0;
                f.den = '0;
            end
            else if (mag == 0)
            begin
                f.num = '0;
                f.den = fra_pkg::DEN_W'(1);
            end
            else
            begin
                x = mag;
                y = den;
                while (y != 0)
                begin
                    r = x % y;
                    x = y;
                    y = r;
                end
                rn = mag / x;
                rd = den / x;
                if (neg) rn = -rn;
                f.num = rn[fra_pkg::NUM_W-1:0];
                f.den = rd[fra_pkg::DEN_W-1:0];
            end
            return f;
        endfunction

        function void note_input(fra_pkg::op_t o, logic [OPW-1:0] a, logic [OPW-1:0] b,
                                 logic [OPW-1:0] c, logic [OPW-1:0] d);
            expected_fracs.push_back(reduce_fraction(o, a, b, c, d));
        endfunction

        task check_result(logic signed [fra_pkg::NUM_W-1:0] rn,
                          logic [fra_pkg::DEN_W-1:0] rd);
            frac_t f;
            if (expected_fracs.size() == 0)
                report($sformatf("result %0d/%0d with nothing outstanding", rn, rd));
            else
            begin
                f = expected_fracs.pop_front();
                if (rn !== f.num)
                    report($sformatf("%s: res_num %0d, want %0d", f.what, rn, f.num));
                if (rd !== f.den)
                    report($sformatf("%s: res_den %0d, want %0d", f.what, rd, f.den));
            end
        endtask
    endclass

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           in_valid = 1'b0;
    logic           in_ready;
    fra_pkg::op_t   op = fra_pkg::OP_ADD;
    logic [OPW-1:0] num_a = '0;
    logic [OPW-1:0] den_a = '0;
    logic [OPW-1:0] num_b = '0;
    logic [OPW-1:0] den_b = '0;
    logic           out_valid;
    logic           out_ready = 1'b0;
    logic signed [fra_pkg::NUM_W-1:0] res_num;
    logic [fra_pkg::DEN_W-1:0]        res_den;

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  hold_req = 1'b0;
    bit  hold_done = 1'b0;
    int  hold_left = 0;
    int  quiet_cycles = 0;

    frac_scoreboard sb = new();

    fraction_arith_reduce_unit #(.OPERAND_BITS(OPW)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .num_a     (num_a),
        .den_a     (den_a),
        .num_b     (num_b),
        .den_b     (den_b),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res_num   (res_num),
        .res_den   (res_den)
    );

    always #5 clk = ~clk;

    // both channels sampled with pre-edge values
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_input(op, num_a, den_a, num_b, den_b);
            if (out_valid && out_ready)
                sb.check_result(res_num, res_den);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no beat for %0d cycles", STALL_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    // receiver, with one long hold-off so the unit backs up into its input
    always @(negedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // called at a falling edge, returns at the falling edge after the beat
    task automatic send_frac(input fra_pkg::op_t o, input logic [OPW-1:0] a,
                             input logic [OPW-1:0] b, input logic [OPW-1:0] c,
                             input logic [OPW-1:0] d);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        num_a <= a;
        den_a <= b;
        num_b <= c;
        den_b <= d;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [OPW-1:0] pick_operand(int zero_pct);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < zero_pct) return '0;
        if (sel < zero_pct + 8) return '1;
        if (sel < zero_pct + 30) return OPW'($urandom_range(1, 15));
        return OPW'($urandom_range(1, 255));
    endfunction

    task automatic send_random_fracs(input int count);
        fra_pkg::op_t   o;
        logic [OPW-1:0] a, b, c, d;
        int             k;
        repeat (count)
        begin
            o = fra_pkg::op_t'($urandom_range(0, 3));
            a = pick_operand(6);
            b = pick_operand(2);
            c = pick_operand(4);
            d = pick_operand(2);
            // equal ratios give zero differences and whole quotients
            if ($urandom_range(0, 7) == 0)
            begin
                k = $urandom_range(1, 3);
                if (a <= 85 && b <= 85)
                begin
                    c = OPW'(a * k);
                    d = OPW'(b * k);
                end
                else
                begin
                    c = a;
                    d = b;
                end
            end
            send_frac(o, a, b, c, d);
        end
    endtask

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 36;
        recv_idle_pct = 75;
        send_frac(fra_pkg::OP_ADD, 8'd1, 8'd1, 8'd1, 8'd1);
        send_frac(fra_pkg::OP_ADD, 8'd255, 8'd255, 8'd255, 8'd255);
        send_frac(fra_pkg::OP_SUB, 8'd255, 8'd1, 8'd255, 8'd1);
        send_frac(fra_pkg::OP_SUB, 8'd1, 8'd255, 8'd255, 8'd1);
        send_frac(fra_pkg::OP_SUB, 8'd0, 8'd1, 8'd1, 8'd1);
        send_frac(fra_pkg::OP_MUL, 8'd255, 8'd1, 8'd255, 8'd1);
        send_frac(fra_pkg::OP_MUL, 8'd1, 8'd255, 8'd1, 8'd255);
        send_frac(fra_pkg::OP_DIV, 8'd255, 8'd1, 8'd1, 8'd255);
        send_frac(fra_pkg::OP_DIV, 8'd1, 8'd255, 8'd255, 8'd1);
        send_frac(fra_pkg::OP_ADD, 8'd0, 8'd7, 8'd0, 8'd9);
        send_frac(fra_pkg::OP_MUL, 8'd0, 8'd5, 8'd3, 8'd4);
        send_frac(fra_pkg::OP_ADD, 8'd3, 8'd0, 8'd5, 8'd7);
        send_frac(fra_pkg::OP_SUB, 8'd3, 8'd4, 8'd5, 8'd0);
        send_frac(fra_pkg::OP_DIV, 8'd3, 8'd4, 8'd0, 8'd7);
        send_frac(fra_pkg::OP_MUL, 8'd255, 8'd0, 8'd255, 8'd0);
        send_frac(fra_pkg::OP_ADD, 8'd0, 8'd0, 8'd0, 8'd0);
        send_frac(fra_pkg::OP_ADD, 8'd255, 8'd254, 8'd253, 8'd255);
        send_frac(fra_pkg::OP_SUB, 8'd1, 8'd254, 8'd255, 8'd1);
        send_frac(fra_pkg::OP_DIV, 8'd6, 8'd4, 8'd3, 8'd8);
        send_frac(fra_pkg::OP_ADD, 8'd1, 8'd2, 8'd1, 8'd3);
        send_frac(fra_pkg::OP_SUB, 8'd1, 8'd3, 8'd1, 8'd2);
        send_frac(fra_pkg::OP_DIV, 8'd0, 8'd9, 8'd7, 8'd5);
        send_random_fracs(250);

        send_idle_pct = 75;
        recv_idle_pct = 36;
        send_random_fracs(250);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1'b1;
        send_random_fracs(250);
        in_valid <= 1'b0;

        while (sb.expected_fracs.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
